>>> rtl/p2pa_pkg.sv
// shared types, codes and the per-class growth table for the pool allocator
`default_nettype none

package p2pa_pkg;

    // request commands
    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_RESIZE = 2'd2;

    // response status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOBLOCK = 3'd1;
    localparam logic [2:0] ST_FOREIGN = 3'd2;
    localparam logic [2:0] ST_DOUBLE  = 3'd3;
    localparam logic [2:0] ST_NOTHING = 3'd4;

    // smallest class and width of a class counter (covers 0..63)
    localparam int unsigned FIRST_CLASS = 3;
    localparam int unsigned CLS_W       = 6;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ATRY,
        S_POPT,
        S_GROW,
        S_RELRD,
        S_RELDO,
        S_DONE
    } state_t;

    // how the response is formed when it is loaded
    typedef enum logic [2:0] {
        RC_NOTHING,
        RC_FOREIGN,
        RC_HANDLE,
        RC_ALLOC,
        RC_FREE,
        RC_MOVE
    } rc_t;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic use_ic;
        logic cls_next;
        logic pop_rd;
        logic pop_take;
        logic grow_start;
        logic grow_write;
        logic grow_take;
        logic rel_rd;
        logic rel_do;
        logic out_load;
        rc_t  rc;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic is_free;
        logic is_resize;
        logic has;
        logic size_zero;
        logic ours;
        logic hfits;
        logic cls_end;
        logic cls_fits;
        logic stk_ne;
        logic can_grow;
        logic fill_done;
        logic out_busy;
    } sts_t;

    // slots added when a class with an empty stack grows
    function automatic logic [3:0] grow_step(input logic [CLS_W-1:0] c);
        logic [3:0] n;
        if (c < CLS_W'(FIRST_CLASS))
            n = 4'd0;
        else if (c <= CLS_W'(11))
            n = 4'd8;
        else if (c == CLS_W'(12))
            n = 4'd4;
        else if (c == CLS_W'(13))
            n = 4'd2;
        else if (c <= CLS_W'(21))
            n = 4'd1;
        else
            n = 4'd0;
        return n;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pow2_class_pool_allocator_core.sv
// top level of the power-of-two size class pool allocator
`default_nettype none

// Pool allocator with size classes 2^3 .. 2^(CLASS_LIMIT-1) bytes. Each class keeps a
// LIFO stack of free slot indices; an empty class grows by 8, 4, 2 or 1 slots (by class)
// up to SLOTS_PER_CLASS, and an alloc walks upward from the smallest class that could
// fit. Free checks ownership and reports double frees; resize keeps the handle when it
// is large enough, else allocates a new block and releases the old one. One request is
// handled at a time: it is accepted in the idle state and dispatched; an alloc walks
// the classes upward from class 3 and takes a slot by a pop or by a growth that writes
// the new slots; a free or a move reads and releases the old slot; last the response
// is loaded. The class walk and the single-port free stack memory set how long a request
// takes. After reset a clearing pass over all CLASS_LIMIT*SLOTS_PER_CLASS slots wipes
// the in-use bits, and no request is taken until it ends. The response sits in its own
// register, so a finished response may wait while the next request is taken.

module pow2_class_pool_allocator_core #(
    parameter int unsigned CLASS_LIMIT     = 22,
    parameter int unsigned SLOTS_PER_CLASS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] req_size,
    input  wire logic        has_handle,
    input  wire logic [4:0]  in_class,
    input  wire logic [3:0]  in_slot,
    // response channel
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic             ok,
    output logic [2:0]       status,
    output logic [4:0]       out_class,
    output logic [3:0]       out_slot
);

    p2pa_pkg::ctl_t ctl;
    p2pa_pkg::sts_t sts;
    logic           busy;

    // controller only takes a request in its idle state
    assign req_stall = busy;

    p2pa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .busy      (busy),
        .sts       (sts),
        .ctl       (ctl)
    );

    p2pa_dp #(
        .CLASS_LIMIT     (CLASS_LIMIT),
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_size   (req_size),
        .has_handle (has_handle),
        .in_class   (in_class),
        .in_slot    (in_slot),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .ok         (ok),
        .status     (status),
        .out_class  (out_class),
        .out_slot   (out_slot),
        .ctl        (ctl),
        .sts        (sts)
    );

endmodule

`default_nettype wire

>>> rtl/p2pa_ctrl.sv
// sequencing state machine of the pool allocator
`default_nettype none

module p2pa_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 busy,
    input  wire p2pa_pkg::sts_t  sts,
    output p2pa_pkg::ctl_t       ctl
);

    p2pa_pkg::state_t state_reg, state_next;
    p2pa_pkg::rc_t    rc_reg, rc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= p2pa_pkg::S_CLEAR;
            rc_reg    <= p2pa_pkg::RC_NOTHING;
        end
        else
        begin
            state_reg <= state_next;
            rc_reg    <= rc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rc_next    = rc_reg;
        ctl        = '0;
        ctl.rc     = rc_reg;
        busy       = 1'b1;
        unique case (state_reg)
            p2pa_pkg::S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = p2pa_pkg::S_IDLE;
            end
            p2pa_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = p2pa_pkg::S_DISPATCH;
                end
            end
            p2pa_pkg::S_DISPATCH:
            begin
                ctl.use_ic = 1'b1;
                state_next = p2pa_pkg::S_DONE;
                priority if (sts.is_alloc)
                begin
                    if (sts.size_zero)
                        rc_next = p2pa_pkg::RC_NOTHING;
                    else
                    begin
                        rc_next    = p2pa_pkg::RC_ALLOC;
                        state_next = p2pa_pkg::S_ATRY;
                    end
                end
                else if (sts.is_free)
                begin
                    priority if (!sts.has)
                        rc_next = p2pa_pkg::RC_NOTHING;
                    else if (!sts.ours)
                        rc_next = p2pa_pkg::RC_FOREIGN;
                    else
                    begin
                        rc_next    = p2pa_pkg::RC_FREE;
                        state_next = p2pa_pkg::S_RELRD;
                    end
                end
                else if (sts.is_resize)
                begin
                    priority if (!sts.ours)
                        rc_next = p2pa_pkg::RC_FOREIGN;
                    else if (sts.hfits)
                        rc_next = p2pa_pkg::RC_HANDLE;
                    else
                    begin
                        rc_next    = p2pa_pkg::RC_MOVE;
                        state_next = p2pa_pkg::S_ATRY;
                    end
                end
                else
                    rc_next = p2pa_pkg::RC_NOTHING;
            end
            p2pa_pkg::S_ATRY:
            begin
                priority if (sts.cls_end)
                    state_next = sts.is_resize ? p2pa_pkg::S_RELRD : p2pa_pkg::S_DONE;
                else if (!sts.cls_fits)
                    ctl.cls_next = 1'b1;
                else if (sts.stk_ne)
                begin
                    ctl.pop_rd = 1'b1;
                    state_next = p2pa_pkg::S_POPT;
                end
                else if (sts.can_grow)
                begin
                    ctl.grow_start = 1'b1;
                    state_next     = p2pa_pkg::S_GROW;
                end
                else
                    ctl.cls_next = 1'b1;
            end
            p2pa_pkg::S_POPT:
            begin
                ctl.pop_take = 1'b1;
                state_next   = sts.is_resize ? p2pa_pkg::S_RELRD : p2pa_pkg::S_DONE;
            end
            p2pa_pkg::S_GROW:
            begin
                if (sts.fill_done)
                begin
                    ctl.grow_take = 1'b1;
                    state_next    = sts.is_resize ? p2pa_pkg::S_RELRD : p2pa_pkg::S_DONE;
                end
                else
                    ctl.grow_write = 1'b1;
            end
            p2pa_pkg::S_RELRD:
            begin
                ctl.use_ic = 1'b1;
                ctl.rel_rd = 1'b1;
                state_next = p2pa_pkg::S_RELDO;
            end
            p2pa_pkg::S_RELDO:
            begin
                ctl.use_ic = 1'b1;
                ctl.rel_do = 1'b1;
                state_next = p2pa_pkg::S_DONE;
            end
            p2pa_pkg::S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = p2pa_pkg::S_IDLE;
                end
            end
            default:
                state_next = p2pa_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/p2pa_dp.sv
// datapath: request latch, per-class counters, free stacks, in-use bits, response register
`default_nettype none

module p2pa_dp #(
    parameter int unsigned CLASS_LIMIT     = 22,
    parameter int unsigned SLOTS_PER_CLASS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [1:0]      cmd,
    input  wire logic [31:0]     req_size,
    input  wire logic            has_handle,
    input  wire logic [4:0]      in_class,
    input  wire logic [3:0]      in_slot,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output logic                 ok,
    output logic [2:0]           status,
    output logic [4:0]           out_class,
    output logic [3:0]           out_slot,
    input  wire p2pa_pkg::ctl_t  ctl,
    output p2pa_pkg::sts_t       sts
);

    localparam int unsigned CW    = $clog2(CLASS_LIMIT);
    localparam int unsigned SW    = $clog2(SLOTS_PER_CLASS);
    localparam int unsigned DW    = $clog2(SLOTS_PER_CLASS + 1);
    localparam int unsigned CLS_W = p2pa_pkg::CLS_W;

    // latched request
    logic [1:0]       cmd_reg;
    logic [31:0]      size_reg;
    logic             has_reg;
    logic [4:0]       ic_reg;
    logic [3:0]       is_reg;

    // walk state
    logic [CLS_W-1:0] c_reg;
    logic [2:0]       j_reg;
    logic [SW-1:0]    a_slot_reg;
    logic             got_reg;
    logic [2:0]       fst_reg;

    // clearing pass counters
    logic [CW-1:0]    cc_reg;
    logic [SW-1:0]    cs_reg;

    // per-class counters
    logic [DW-1:0]    depth_reg   [CLASS_LIMIT];
    logic [DW-1:0]    granted_reg [CLASS_LIMIT];

    // memories
    logic [SW-1:0]    fs_mem [CLASS_LIMIT][SLOTS_PER_CLASS];
    logic             iu_mem [CLASS_LIMIT][SLOTS_PER_CLASS];
    logic [SW-1:0]    fs_rd_reg;
    logic             iu_rd_reg;

    logic             out_valid_reg;
    logic             ok_reg;
    logic [2:0]       st_reg;
    logic [4:0]       oc_reg;
    logic [3:0]       os_reg;

    logic [CLS_W-1:0] acls;
    logic             acls_ok;
    logic [CW-1:0]    ai;
    logic [DW-1:0]    depth_sel;
    logic [DW-1:0]    gr_sel;
    logic [3:0]       n;
    logic [CW-1:0]    ci;
    logic [CW-1:0]    ii;
    logic [SW-1:0]    isw;

    logic             fs_we;
    logic [CW-1:0]    fs_wc;
    logic [SW-1:0]    fs_ws;
    logic [SW-1:0]    fs_wd;
    logic             iu_we;
    logic [CW-1:0]    iu_wc;
    logic [SW-1:0]    iu_ws;
    logic             iu_wd;

    assign acls    = ctl.use_ic ? CLS_W'(ic_reg) : c_reg;
    assign acls_ok = acls < CLS_W'(CLASS_LIMIT);
    assign ai      = acls[CW-1:0];
    assign depth_sel = acls_ok ? depth_reg[ai]   : '0;
    assign gr_sel    = acls_ok ? granted_reg[ai] : '0;
    assign n       = p2pa_pkg::grow_step(c_reg);
    assign ci      = c_reg[CW-1:0];
    assign ii      = ic_reg[CW-1:0];
    assign isw     = SW'(is_reg);

    always_comb
    begin
        sts.clr_last  = (cc_reg == CW'(CLASS_LIMIT - 1)) && (cs_reg == SW'(SLOTS_PER_CLASS - 1));
        sts.is_alloc  = (cmd_reg == p2pa_pkg::CMD_ALLOC)
                     || ((cmd_reg == p2pa_pkg::CMD_RESIZE) && !has_reg);
        sts.is_free   = cmd_reg == p2pa_pkg::CMD_FREE;
        sts.is_resize = (cmd_reg == p2pa_pkg::CMD_RESIZE) && has_reg;
        sts.has       = has_reg;
        sts.size_zero = size_reg == 32'd0;
        sts.ours      = has_reg && (ic_reg >= 5'(p2pa_pkg::FIRST_CLASS))
                     && (CLS_W'(ic_reg) < CLS_W'(CLASS_LIMIT)) && (DW'(is_reg) < gr_sel)
                     && ((DW + 1)'(is_reg) < (DW + 1)'(SLOTS_PER_CLASS));
        sts.hfits     = (33'd1 << ic_reg) >= {1'b0, size_reg};
        sts.cls_end   = c_reg >= CLS_W'(CLASS_LIMIT);
        sts.cls_fits  = {1'b0, size_reg} <= (33'd1 << c_reg);
        sts.stk_ne    = depth_sel != '0;
        sts.can_grow  = (n != 4'd0)
                     && (({1'b0, gr_sel} + (DW + 1)'(n)) <= (DW + 1)'(SLOTS_PER_CLASS));
        sts.fill_done = {1'b0, j_reg} == (n - 4'd1);
        sts.out_busy  = out_valid_reg && rsp_stall;
    end

    // write port selection for both memories
    always_comb
    begin
        fs_we = 1'b0;
        fs_wc = ci;
        fs_ws = SW'(j_reg);
        fs_wd = SW'(gr_sel + DW'(n) - DW'(j_reg) - DW'(1));
        if (ctl.grow_write)
            fs_we = 1'b1;
        else if (ctl.rel_do && iu_rd_reg)
        begin
            fs_we = 1'b1;
            fs_wc = ii;
            fs_ws = SW'(depth_sel);
            fs_wd = isw;
        end

        iu_we = 1'b0;
        iu_wc = ci;
        iu_ws = fs_rd_reg;
        iu_wd = 1'b1;
        priority if (ctl.clr_step)
        begin
            iu_we = 1'b1;
            iu_wc = cc_reg;
            iu_ws = cs_reg;
            iu_wd = 1'b0;
        end
        else if (ctl.pop_take)
            iu_we = 1'b1;
        else if (ctl.grow_take)
        begin
            iu_we = 1'b1;
            iu_ws = SW'(gr_sel);
        end
        else if (ctl.rel_do && iu_rd_reg)
        begin
            iu_we = 1'b1;
            iu_wc = ii;
            iu_ws = isw;
            iu_wd = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
            fs_mem[fs_wc][fs_ws] <= fs_wd;
        if (ctl.pop_rd)
            fs_rd_reg <= fs_mem[ci][SW'(depth_sel - DW'(1))];
        if (iu_we)
            iu_mem[iu_wc][iu_ws] <= iu_wd;
        if (ctl.rel_rd)
            iu_rd_reg <= iu_mem[ii][isw];
    end

    // request latch and walk registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            size_reg <= req_size;
            has_reg  <= has_handle;
            ic_reg   <= in_class;
            is_reg   <= in_slot;
            c_reg    <= CLS_W'(p2pa_pkg::FIRST_CLASS);
            got_reg  <= 1'b0;
        end
        else if (ctl.cls_next)
            c_reg <= c_reg + CLS_W'(1);
        if (ctl.grow_start)
            j_reg <= 3'd0;
        else if (ctl.grow_write)
            j_reg <= j_reg + 3'd1;
        if (ctl.pop_take)
        begin
            a_slot_reg <= fs_rd_reg;
            got_reg    <= 1'b1;
        end
        else if (ctl.grow_take)
        begin
            a_slot_reg <= SW'(gr_sel);
            got_reg    <= 1'b1;
        end
        if (ctl.rel_do)
            fst_reg <= iu_rd_reg ? p2pa_pkg::ST_OK : p2pa_pkg::ST_DOUBLE;
    end

    // per-class counters and the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CLASS_LIMIT; k++)
            begin
                depth_reg[k]   <= '0;
                granted_reg[k] <= '0;
            end
            cc_reg <= '0;
            cs_reg <= '0;
        end
        else
        begin
            if (ctl.pop_rd)
                depth_reg[ai] <= depth_sel - DW'(1);
            else if (ctl.grow_take)
            begin
                depth_reg[ai]   <= DW'(n) - DW'(1);
                granted_reg[ai] <= gr_sel + DW'(n);
            end
            else if (ctl.rel_do && iu_rd_reg)
                depth_reg[ai] <= depth_sel + DW'(1);
            if (ctl.clr_step)
            begin
                if (cs_reg == SW'(SLOTS_PER_CLASS - 1))
                begin
                    cs_reg <= '0;
                    cc_reg <= cc_reg + CW'(1);
                end
                else
                    cs_reg <= cs_reg + SW'(1);
            end
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.out_load)
            out_valid_reg <= 1'b1;
        else if (!rsp_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            ok_reg <= 1'b0;
            st_reg <= p2pa_pkg::ST_NOTHING;
            oc_reg <= 5'd0;
            os_reg <= 4'd0;
            unique case (ctl.rc)
                p2pa_pkg::RC_NOTHING:
                    st_reg <= p2pa_pkg::ST_NOTHING;
                p2pa_pkg::RC_FOREIGN:
                    st_reg <= p2pa_pkg::ST_FOREIGN;
                p2pa_pkg::RC_HANDLE:
                begin
                    ok_reg <= 1'b1;
                    st_reg <= p2pa_pkg::ST_OK;
                    oc_reg <= ic_reg;
                    os_reg <= is_reg;
                end
                p2pa_pkg::RC_FREE:
                    st_reg <= fst_reg;
                p2pa_pkg::RC_ALLOC, p2pa_pkg::RC_MOVE:
                begin
                    if (got_reg)
                    begin
                        ok_reg <= 1'b1;
                        st_reg <= (ctl.rc == p2pa_pkg::RC_MOVE) ? fst_reg : p2pa_pkg::ST_OK;
                        oc_reg <= 5'(c_reg);
                        os_reg <= 4'(a_slot_reg);
                    end
                    else
                        st_reg <= p2pa_pkg::ST_NOBLOCK;
                end
                default:
                    st_reg <= p2pa_pkg::ST_NOTHING;
            endcase
        end
    end

    assign rsp_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign status    = st_reg;
    assign out_class = oc_reg;
    assign out_slot  = os_reg;

    a_depth_le_granted: assert property (@(posedge clk) disable iff (!rst_n)
        acls_ok |-> depth_sel <= gr_sel)
        else $error("free depth above granted slots");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop_rd |-> sts.stk_ne)
        else $error("pop from empty free stack");

    a_grow_legal: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.grow_take |-> sts.can_grow)
        else $error("class grown past its limit");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> !sts.out_busy)
        else $error("response overwritten while waiting");

endmodule

`default_nettype wire

>>> bench/tb.sv
// testbench for the power-of-two size class pool allocator core
`default_nettype none

module tb;

    localparam int unsigned NCLS  = 22;
    localparam int unsigned NSLOT = 16;
    localparam int unsigned NRAND = 1000;

    // expected response of one request
    typedef struct packed {
        logic       ok;
        logic [2:0] status;
        logic [4:0] cls;
        logic [3:0] slot;
    } rsp_t;

    // pool model: free stacks, grants and in-use bits, plus the queue of expected responses
    class pool_scoreboard;
        logic [3:0] stk [NCLS][NSLOT];
        int unsigned depth [NCLS];
        int unsigned granted [NCLS];
        bit busy [NCLS][NSLOT];
        rsp_t pending [$];
        int errors;

        function void clear();
            foreach (depth[c]) begin
                depth[c] = 0;
                granted[c] = 0;
                foreach (busy[c][s]) busy[c][s] = 0;
            end
            pending.delete();
            errors = 0;
        endfunction

        function int unsigned growth(int unsigned c);
            if (c < p2pa_pkg::FIRST_CLASS) return 0;
            if (c <= 11) return 8;
            if (c == 12) return 4;
            if (c == 13) return 2;
            if (c <= 21) return 1;
            return 0;
        endfunction

        function bit pop_slot(int unsigned c, output logic [3:0] s);
            int unsigned n;
            if (depth[c] == 0) begin
                n = growth(c);
                if (n == 0 || granted[c] + n > NSLOT) return 0;
                for (int k = n; k > 0; k--) begin
                    stk[c][depth[c]] = 4'(granted[c] + k - 1);
                    depth[c]++;
                end
                granted[c] += n;
            end
            depth[c]--;
            s = stk[c][depth[c]];
            busy[c][s] = 1;
            return 1;
        endfunction

        function bit grab(logic [31:0] sz, output logic [4:0] c, output logic [3:0] s);
            if (sz == 0) return 0;
            for (int unsigned k = p2pa_pkg::FIRST_CLASS; k < NCLS; k++)
                if (64'(sz) <= (64'd1 << k) && pop_slot(k, s)) begin
                    c = 5'(k);
                    return 1;
                end
            return 0;
        endfunction

        function bit owned(logic h, logic [4:0] c, logic [3:0] s);
            return h && c >= p2pa_pkg::FIRST_CLASS && c < NCLS && s < granted[c];
        endfunction

        function logic [2:0] give_back(logic [4:0] c, logic [3:0] s);
            if (!busy[c][s]) return p2pa_pkg::ST_DOUBLE;
            busy[c][s] = 0;
            stk[c][depth[c]] = s;
            depth[c]++;
            return p2pa_pkg::ST_OK;
        endfunction

        // note an accepted request and queue its expected response
        function void note_request(logic [1:0] op, logic [31:0] sz, logic h,
                                   logic [4:0] ic, logic [3:0] is);
            rsp_t r;
            logic [4:0] c;
            logic [3:0] s;
            logic [2:0] fst;
            bit got;
            r = '{ok: 0, status: p2pa_pkg::ST_NOTHING, cls: 0, slot: 0};
            if (op == p2pa_pkg::CMD_ALLOC || (op == p2pa_pkg::CMD_RESIZE && !h)) begin
                if (sz == 0) r.status = p2pa_pkg::ST_NOTHING;
                else if (grab(sz, c, s))
                    r = '{ok: 1, status: p2pa_pkg::ST_OK, cls: c, slot: s};
                else r.status = p2pa_pkg::ST_NOBLOCK;
            end else if (op == p2pa_pkg::CMD_FREE) begin
                if (!h) r.status = p2pa_pkg::ST_NOTHING;
                else if (!owned(h, ic, is)) r.status = p2pa_pkg::ST_FOREIGN;
                else r.status = give_back(ic, is);
            end else if (op == p2pa_pkg::CMD_RESIZE) begin
                if (!owned(h, ic, is)) r.status = p2pa_pkg::ST_FOREIGN;
                else if ((64'd1 << ic) >= 64'(sz))
                    r = '{ok: 1, status: p2pa_pkg::ST_OK, cls: ic, slot: is};
                else begin
                    got = grab(sz, c, s);
                    fst = give_back(ic, is);
                    if (got) r = '{ok: 1, status: fst, cls: c, slot: s};
                    else r.status = p2pa_pkg::ST_NOBLOCK;
                end
            end
            pending.push_back(r);
        endfunction

        // compare one response with the oldest expectation
        function void check_response(logic o, logic [2:0] st, logic [4:0] c, logic [3:0] s);
            rsp_t e;
            if (pending.size() == 0) begin
                $error("unexpected response ok=%0d status=%0d", o, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (o !== e.ok) begin
                $error("ok: expected %0d actual %0d", e.ok, o);
                errors++;
            end
            if (st !== e.status) begin
                $error("status: expected %0d actual %0d", e.status, st);
                errors++;
            end
            if (c !== e.cls) begin
                $error("out_class: expected %0d actual %0d", e.cls, c);
                errors++;
            end
            if (s !== e.slot) begin
                $error("out_slot: expected %0d actual %0d", e.slot, s);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  cmd;
    logic [31:0] req_size;
    logic        has_handle;
    logic [4:0]  in_class;
    logic [3:0]  in_slot;
    logic        rsp_valid;
    logic        rsp_stall;
    logic        ok;
    logic [2:0]  status;
    logic [4:0]  out_class;
    logic [3:0]  out_slot;

    pool_scoreboard sb;
    bit calm;           // long stretch with no idling on either side
    logic [4:0] live_cls [$];
    logic [3:0] live_slot [$];

    pow2_class_pool_allocator_core #(
        .CLASS_LIMIT(NCLS),
        .SLOTS_PER_CLASS(NSLOT)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .cmd(cmd), .req_size(req_size), .has_handle(has_handle),
        .in_class(in_class), .in_slot(in_slot),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .ok(ok), .status(status), .out_class(out_class), .out_slot(out_slot)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // sample both handshakes at the rising edge
    always @(posedge clk) begin
        if (rst_n && req_valid && !req_stall)
            sb.note_request(cmd, req_size, has_handle, in_class, in_slot);
        if (rst_n && rsp_valid && !rsp_stall) begin
            sb.check_response(ok, status, out_class, out_slot);
            // remember handles we got back so later frees and resizes hit real blocks
            if (ok && live_cls.size() < 64) begin
                live_cls.push_back(out_class);
                live_slot.push_back(out_slot);
            end
        end
    end

    // response side stalls at random, except during the calm stretch
    always @(negedge clk) begin
        if (!rst_n) rsp_stall <= 1'b0;
        else rsp_stall <= !calm && ($urandom_range(99) < 24);
    end

    // present one request, hold it until it is taken, then maybe idle
    task automatic send(logic [1:0] op, logic [31:0] sz, logic h,
                        logic [4:0] c, logic [3:0] s);
        req_valid <= 1'b1;
        cmd <= op;
        req_size <= sz;
        has_handle <= h;
        in_class <= c;
        in_slot <= s;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
        if (!calm && $urandom_range(99) < 24) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
    endtask

    // random size: mostly small, sometimes zero, sometimes near a class edge, sometimes anything
    function automatic logic [31:0] pick_size();
        int unsigned k;
        k = $urandom_range(21, 3);
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'd0;
            2, 3: return (32'd1 << k) + 32'($urandom_range(1)) - 32'd1;
            default: return 32'($urandom_range(300, 1));
        endcase
    endfunction

    task automatic random_request();
        int unsigned pick;
        int unsigned i;
        pick = $urandom_range(99);
        if (live_cls.size() != 0 && pick < 55) begin
            // free or resize a handle we were given earlier
            i = $urandom_range(live_cls.size() - 1);
            if (pick < 35) begin
                send(p2pa_pkg::CMD_FREE, $urandom(), 1'b1, live_cls[i], live_slot[i]);
                if ($urandom_range(3) != 0) begin
                    live_cls.delete(i);
                    live_slot.delete(i);
                end
            end else
                send(p2pa_pkg::CMD_RESIZE, pick_size(), 1'b1, live_cls[i], live_slot[i]);
        end else if (pick < 85)
            send(p2pa_pkg::CMD_ALLOC, pick_size(), 1'($urandom_range(1)),
                 5'($urandom()), 4'($urandom()));
        else
            // noise: any command, any handle, unknown command included
            send(2'($urandom()), pick_size(), 1'($urandom_range(1)),
                 5'($urandom()), 4'($urandom()));
    endtask

    initial begin
        sb = new();
        sb.clear();
        calm = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        rsp_stall = 1'b0;
        cmd = p2pa_pkg::CMD_ALLOC;
        req_size = '0;
        has_handle = 1'b0;
        in_class = '0;
        in_slot = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed: zero size, extremes, foreign handles, double free, resize paths
        send(p2pa_pkg::CMD_ALLOC, 32'd0, 1'b0, 5'd0, 4'd0);
        send(p2pa_pkg::CMD_ALLOC, 32'd1, 1'b0, 5'd31, 4'd15);
        send(p2pa_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 1'b1, 5'd31, 4'd15);
        send(p2pa_pkg::CMD_ALLOC, 32'h0020_0000, 1'b0, 5'd0, 4'd0);
        send(p2pa_pkg::CMD_ALLOC, 32'h0020_0001, 1'b0, 5'd0, 4'd0);
        send(p2pa_pkg::CMD_FREE, 32'd0, 1'b0, 5'd3, 4'd0);
        send(p2pa_pkg::CMD_FREE, 32'd0, 1'b1, 5'd2, 4'd0);
        send(p2pa_pkg::CMD_FREE, 32'd0, 1'b1, 5'd3, 4'd15);
        send(p2pa_pkg::CMD_FREE, 32'd0, 1'b1, 5'd22, 4'd0);
        send(p2pa_pkg::CMD_FREE, 32'd0, 1'b1, 5'd3, 4'd0);
        send(p2pa_pkg::CMD_FREE, 32'd0, 1'b1, 5'd3, 4'd0);
        send(p2pa_pkg::CMD_RESIZE, 32'd0, 1'b0, 5'd0, 4'd0);
        send(p2pa_pkg::CMD_RESIZE, 32'd100, 1'b0, 5'd0, 4'd0);
        send(p2pa_pkg::CMD_RESIZE, 32'd0, 1'b1, 5'd3, 4'd0);
        send(p2pa_pkg::CMD_RESIZE, 32'd8, 1'b1, 5'd3, 4'd0);
        send(p2pa_pkg::CMD_RESIZE, 32'd5000, 1'b1, 5'd3, 4'd1);
        send(p2pa_pkg::CMD_RESIZE, 32'd9000, 1'b1, 5'd3, 4'd1);
        send(p2pa_pkg::CMD_RESIZE, 32'hFFFF_FFFF, 1'b1, 5'd7, 4'd0);
        send(p2pa_pkg::CMD_RESIZE, 32'd4, 1'b1, 5'd30, 4'd9);
        send(2'd3, 32'd16, 1'b1, 5'd3, 4'd0);
        // exhaust the biggest class so growth fails
        repeat (17) send(p2pa_pkg::CMD_ALLOC, 32'h0010_0001, 1'b0, 5'd0, 4'd0);

        // random part, with a long stretch without idling in the middle
        for (int n = 0; n < NRAND; n++) begin
            calm = (n >= 400 && n < 550);
            random_request();
        end
        calm = 0;
        req_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // generous cap: clearing pass plus ~1100 requests at worst-case walk and stalls
    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
